FILE: hw/rtl/uart_twp_pkg.sv
package uart_twp_pkg;

	localparam int unsigned TICK_COUNT_WIDTH_DEF = 16;
	localparam int unsigned BIT_TIME_WIDTH       = 16;
	localparam int unsigned MODE_WIDTH           = 3;
	localparam int unsigned IN_TDATA_WIDTH       = 16;
	localparam int unsigned OUT_TDATA_WIDTH      = 16;

	localparam logic [BIT_TIME_WIDTH-1:0] BIT_TIME_RESET = 16'd208;

	// register indexes on the config port
	localparam logic CFG_BIT_TIME    = 1'b0;
	localparam logic CFG_PARITY_MODE = 1'b1;

	// parity modes; codes above SPACE behave as NONE
	localparam logic [MODE_WIDTH-1:0] PAR_NONE  = 3'd0;
	localparam logic [MODE_WIDTH-1:0] PAR_ODD   = 3'd1;
	localparam logic [MODE_WIDTH-1:0] PAR_EVEN  = 3'd2;
	localparam logic [MODE_WIDTH-1:0] PAR_MARK  = 3'd3;
	localparam logic [MODE_WIDTH-1:0] PAR_SPACE = 3'd4;

	// transmit bit position: the bit currently on the line
	localparam logic [3:0] TX_IDX_IDLE   = 4'd0;
	localparam logic [3:0] TX_IDX_START  = 4'd1;
	localparam logic [3:0] TX_IDX_BIT6   = 4'd8;
	localparam logic [3:0] TX_IDX_BIT7   = 4'd9;
	localparam logic [3:0] TX_IDX_PARITY = 4'd10;
	localparam logic [3:0] TX_IDX_STOP   = 4'd11;

	// receive bit position: the next bit to be sampled
	localparam logic [3:0] RX_IDX_WAIT   = 4'd0;
	localparam logic [3:0] RX_IDX_BIT0   = 4'd1;
	localparam logic [3:0] RX_IDX_BIT7   = 4'd8;
	localparam logic [3:0] RX_IDX_PARITY = 4'd9;
	localparam logic [3:0] RX_IDX_STOP   = 4'd10;

	typedef struct packed {
		logic line;
		logic accepted;
		logic idle;
	} tx_res_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] data;
		logic       parity_ok;
	} rx_res_t;

	function automatic logic has_parity(input logic [MODE_WIDTH-1:0] mode);
		has_parity = (mode >= PAR_ODD) && (mode <= PAR_SPACE);
	endfunction

endpackage

FILE: hw/rtl/uart_twp_tx.sv
module uart_twp_tx
	import uart_twp_pkg::*;
#(
	parameter int unsigned TICK_COUNT_WIDTH = TICK_COUNT_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      step,
	input  logic                      send_request,
	input  logic [7:0]                send_byte,
	input  logic [BIT_TIME_WIDTH-1:0] bit_time,
	input  logic [MODE_WIDTH-1:0]     parity_mode,
	output tx_res_t                   res
);

	logic [7:0]                  shift_q, shift_d;
	logic [3:0]                  idx_q, idx_d;
	logic [TICK_COUNT_WIDTH-1:0] cnt_q, cnt_d;
	logic                        ones_q, ones_d;
	logic                        level_q, level_d;
	logic                        accepted;
	logic [TICK_COUNT_WIDTH-1:0] bt_ext;

	assign bt_ext = TICK_COUNT_WIDTH'(bit_time);

	always_comb begin
		shift_d  = shift_q;
		idx_d    = idx_q;
		cnt_d    = cnt_q;
		ones_d   = ones_q;
		level_d  = level_q;
		accepted = 1'b0;
		if (idx_q != TX_IDX_IDLE) begin
			if (cnt_q <= TICK_COUNT_WIDTH'(1)) begin
				cnt_d = bt_ext;
				if (idx_q <= TX_IDX_BIT6) begin
					level_d = shift_q[0];
					ones_d  = ones_q ^ shift_q[0];
					shift_d = {1'b0, shift_q[7:1]};
					idx_d   = idx_q + 4'd1;
				end else if (idx_q == TX_IDX_BIT7) begin
					if (!has_parity(parity_mode)) begin
						level_d = 1'b1;
						idx_d   = TX_IDX_STOP;
					end else begin
						idx_d = TX_IDX_PARITY;
						case (parity_mode)
							PAR_ODD:  level_d = ~ones_q;
							PAR_EVEN: level_d = ones_q;
							PAR_MARK: level_d = 1'b1;
							default:  level_d = 1'b0;
						endcase
					end
				end else if (idx_q == TX_IDX_PARITY) begin
					level_d = 1'b1;
					idx_d   = TX_IDX_STOP;
				end else begin
					level_d = 1'b1;
					idx_d   = TX_IDX_IDLE;
					ones_d  = 1'b0;
				end
			end else begin
				cnt_d = cnt_q - TICK_COUNT_WIDTH'(1);
			end
		end
		// a new frame may start on the tick the stop bit ends
		if (idx_d == TX_IDX_IDLE && send_request) begin
			shift_d  = send_byte;
			ones_d   = 1'b0;
			level_d  = 1'b0;
			idx_d    = TX_IDX_START;
			cnt_d    = bt_ext;
			accepted = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= '0;
			idx_q   <= TX_IDX_IDLE;
			cnt_q   <= '0;
			ones_q  <= 1'b0;
			level_q <= 1'b1;
		end else if (step) begin
			shift_q <= shift_d;
			idx_q   <= idx_d;
			cnt_q   <= cnt_d;
			ones_q  <= ones_d;
			level_q <= level_d;
		end
	end

	assign res.line     = level_d;
	assign res.accepted = accepted;
	assign res.idle     = (idx_d == TX_IDX_IDLE);

endmodule

FILE: hw/rtl/uart_twp_rx.sv
module uart_twp_rx
	import uart_twp_pkg::*;
#(
	parameter int unsigned TICK_COUNT_WIDTH = TICK_COUNT_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      step,
	input  logic                      rx_line,
	input  logic [BIT_TIME_WIDTH-1:0] bit_time,
	input  logic [MODE_WIDTH-1:0]     parity_mode,
	output rx_res_t                   res
);

	localparam int unsigned HALF_WIDTH = BIT_TIME_WIDTH + 1;
	localparam int unsigned DW = (TICK_COUNT_WIDTH > HALF_WIDTH) ? TICK_COUNT_WIDTH : HALF_WIDTH;

	logic [7:0]                  shift_q, shift_d;
	logic [3:0]                  idx_q, idx_d;
	logic [TICK_COUNT_WIDTH-1:0] cnt_q, cnt_d;
	logic                        ones_q, ones_d;
	logic                        prev_q;
	logic                        status_q, status_d;
	logic                        total;
	logic [HALF_WIDTH-1:0]       delay_raw;
	logic [DW-1:0]               delay_ext, cnt_max_ext;
	logic [TICK_COUNT_WIDTH-1:0] delay;

	// 1.5 bit times, clipped to the counter range
	assign delay_raw   = HALF_WIDTH'(bit_time) + HALF_WIDTH'(bit_time[BIT_TIME_WIDTH-1:1]);
	assign delay_ext   = DW'(delay_raw);
	assign cnt_max_ext = DW'({TICK_COUNT_WIDTH{1'b1}});
	assign delay = (delay_ext > cnt_max_ext) ? TICK_COUNT_WIDTH'(cnt_max_ext)
	                                         : TICK_COUNT_WIDTH'(delay_ext);

	assign total = ones_q ^ rx_line;

	always_comb begin
		shift_d  = shift_q;
		idx_d    = idx_q;
		cnt_d    = cnt_q;
		ones_d   = ones_q;
		status_d = status_q;
		res      = '0;
		if (idx_q == RX_IDX_WAIT) begin
			if (prev_q && !rx_line) begin
				cnt_d  = delay;
				ones_d = 1'b0;
				idx_d  = RX_IDX_BIT0;
			end
		end else if (cnt_q <= TICK_COUNT_WIDTH'(1)) begin
			cnt_d = TICK_COUNT_WIDTH'(bit_time);
			if (idx_q <= RX_IDX_BIT7) begin
				shift_d = {rx_line, shift_q[7:1]};
				ones_d  = ones_q ^ rx_line;
				idx_d   = idx_q + 4'd1;
			end else if (idx_q == RX_IDX_PARITY && has_parity(parity_mode)) begin
				idx_d = RX_IDX_STOP;
				case (parity_mode)
					PAR_ODD:  status_d = total;
					PAR_EVEN: status_d = ~total;
					PAR_MARK: status_d = rx_line;
					default:  status_d = ~rx_line;
				endcase
			end else begin
				// stop bit sampled, level not checked
				if (idx_q == RX_IDX_PARITY) begin
					status_d = 1'b1;
				end
				res.valid     = 1'b1;
				res.data      = shift_q;
				res.parity_ok = status_d;
				idx_d         = RX_IDX_WAIT;
			end
		end else begin
			cnt_d = cnt_q - TICK_COUNT_WIDTH'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q  <= '0;
			idx_q    <= RX_IDX_WAIT;
			cnt_q    <= '0;
			ones_q   <= 1'b0;
			prev_q   <= 1'b1;
			status_q <= 1'b0;
		end else if (step) begin
			shift_q  <= shift_d;
			idx_q    <= idx_d;
			cnt_q    <= cnt_d;
			ones_q   <= ones_d;
			prev_q   <= rx_line;
			status_q <= status_d;
		end
	end

endmodule

FILE: hw/rtl/uart_transceiver_with_parity.sv
// UART transceiver, 8 data bits, optional parity, one stop bit.
// Each beat on the s_ side is one tick of the bit timer: it carries the sampled
// receive line level and, optionally, a byte offered for sending. Every accepted
// beat yields exactly one result beat on the m_ side with the transmit line level,
// the send handshake flags and, on the tick a frame completes, the received byte.
// Result: registered in the output register, or the skid stage during a stall.
// Throughput: one beat per cycle unless s_tready is low; all work for a tick is a
// single pass of counter and shift logic between timer state and the output register.
// Stall: the output register plus a one-beat skid stage let one more beat be taken
// while m_tready is low; after that s_tready drops. Timer state only advances on
// accepted beats, so a stall simply freezes line timing.
// Reset: both directions go idle, the transmit line reads high, bit_time returns to
// 208 ticks and parity to none. Write the config port only while no beat is pending.
module uart_transceiver_with_parity
	import uart_twp_pkg::*;
#(
	parameter int unsigned TICK_COUNT_WIDTH = TICK_COUNT_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// [0] rx_line, [1] send_request, [9:2] send_byte, [15:10] zero
	input  logic [IN_TDATA_WIDTH-1:0]  s_tdata,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// [0] tx_line, [1] send_accepted, [2] tx_idle, [3] rx_valid,
	// [11:4] rx_byte, [12] rx_parity_ok, [15:13] zero
	output logic [OUT_TDATA_WIDTH-1:0] m_tdata,
	input  logic                       cfg_we,
	input  logic                       cfg_addr,
	input  logic [BIT_TIME_WIDTH-1:0]  cfg_wdata
);

	logic [BIT_TIME_WIDTH-1:0]  bit_time_q;
	logic [MODE_WIDTH-1:0]      parity_mode_q;
	logic                       step;
	tx_res_t                    tx_res;
	rx_res_t                    rx_res;
	logic [OUT_TDATA_WIDTH-1:0] res_word;
	logic [OUT_TDATA_WIDTH-1:0] out_q, skid_q;
	logic                       out_valid_q, skid_valid_q;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_time_q    <= BIT_TIME_RESET;
			parity_mode_q <= PAR_NONE;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_BIT_TIME:    bit_time_q    <= cfg_wdata;
				CFG_PARITY_MODE: parity_mode_q <= cfg_wdata[MODE_WIDTH-1:0];
				default:         ;
			endcase
		end
	end

	// skid stage empty means room for at least one more beat
	assign s_tready = ~skid_valid_q;
	assign step     = s_tvalid & s_tready;

	uart_twp_tx #(
		.TICK_COUNT_WIDTH(TICK_COUNT_WIDTH)
	) u_tx (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.send_request (s_tdata[1]),
		.send_byte    (s_tdata[9:2]),
		.bit_time     (bit_time_q),
		.parity_mode  (parity_mode_q),
		.res          (tx_res)
	);

	uart_twp_rx #(
		.TICK_COUNT_WIDTH(TICK_COUNT_WIDTH)
	) u_rx (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.rx_line     (s_tdata[0]),
		.bit_time    (bit_time_q),
		.parity_mode (parity_mode_q),
		.res         (rx_res)
	);

	assign res_word = {3'b000, rx_res.parity_ok, rx_res.data, rx_res.valid,
	                   tx_res.idle, tx_res.accepted, tx_res.line};

	// output register with skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_valid_q && m_tready) begin
			// skid full blocks step, so at most one of the two refills the output
			out_valid_q  <= skid_valid_q | step;
			skid_valid_q <= 1'b0;
		end else if (step) begin
			if (out_valid_q) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_valid_q && m_tready && skid_valid_q) begin
			out_q <= skid_q;
		end else if (step && (!out_valid_q || m_tready)) begin
			out_q <= res_word;
		end
		if (step && out_valid_q && !m_tready) begin
			skid_q <= res_word;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

endmodule

FILE: hw/rtl/uart_twp_checker.sv
module uart_twp_checker
	import uart_twp_pkg::*;
(
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_tvalid,
	input logic                       s_tready,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [OUT_TDATA_WIDTH-1:0] m_tdata
);

	// a byte taken starts the frame with the start bit on the line
	a_accept_starts_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[1]) |-> (!m_tdata[0] && !m_tdata[2]))
		else $error("send accepted without start bit");

	// an idle transmitter holds the line high
	a_idle_line_high: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[2]) |-> m_tdata[0])
		else $error("tx idle but line low");

	// receive fields are zero outside a completed frame
	a_rx_fields_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[3]) |-> (m_tdata[11:4] == 8'h00 && !m_tdata[12]))
		else $error("rx fields set without rx_valid");

	// stalled beat holds
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("result beat changed under stall");

	// an accepted tick always leaves a result beat waiting
	a_beat_yields_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> m_tvalid)
		else $error("accepted beat produced no result");

endmodule

bind uart_transceiver_with_parity uart_twp_checker u_uart_twp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
